FILE: hdl/gakf_pkg.sv
package gakf_pkg;

   localparam int W = 48;
   localparam int NUM_STEPS = 32;
   localparam int PC_W = $clog2(NUM_STEPS);

   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] COV_RESET = 48'sd42949672960;   // 10.0
   localparam logic [W-2:0] ANGLE_NOISE_RESET = 47'd429;
   localparam logic [W-2:0] BIAS_NOISE_RESET = 47'd42950;
   localparam logic [W-2:0] MEAS_NOISE_RESET = 47'd8589934592;      // 2.0

   typedef enum logic [1:0] {
      CSR_ANGLE_NOISE = 2'd0,
      CSR_BIAS_NOISE  = 2'd1,
      CSR_MEAS_NOISE  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      R_ANG, R_BIAS, R_AA, R_AB, R_BA, R_BB, R_T, R_Y, R_S, R_KA, R_KB, R_M,
      R_MEAS, R_RATE, R_DT, R_QA, R_QB, R_MN, R_ZERO
   } reg_type;

   typedef struct packed {
      op_type  op;
      reg_type dst;
      reg_type sa;
      reg_type sb;
   } step_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } cmd_type;

   typedef struct packed {
      logic                done;
      logic signed [W-1:0] value;
   } res_type;

   function automatic step_type program_step(input logic [PC_W-1:0] pc);
      step_type s;
      s = '{OP_ADD, R_T, R_ZERO, R_ZERO};
      unique case (pc)
         5'd0:  s = '{OP_SUB, R_T,    R_RATE, R_BIAS};
         5'd1:  s = '{OP_MUL, R_M,    R_DT,   R_T};
         5'd2:  s = '{OP_ADD, R_ANG,  R_ANG,  R_M};
         5'd3:  s = '{OP_MUL, R_M,    R_BB,   R_DT};
         5'd4:  s = '{OP_SUB, R_T,    R_M,    R_AB};
         5'd5:  s = '{OP_SUB, R_T,    R_T,    R_BA};
         5'd6:  s = '{OP_ADD, R_T,    R_T,    R_QA};
         5'd7:  s = '{OP_MUL, R_M,    R_DT,   R_T};
         5'd8:  s = '{OP_ADD, R_AA,   R_AA,   R_M};
         5'd9:  s = '{OP_MUL, R_M,    R_BB,   R_DT};
         5'd10: s = '{OP_SUB, R_AB,   R_AB,   R_M};
         5'd11: s = '{OP_SUB, R_BA,   R_BA,   R_M};
         5'd12: s = '{OP_MUL, R_M,    R_QB,   R_DT};
         5'd13: s = '{OP_ADD, R_BB,   R_BB,   R_M};
         5'd14: s = '{OP_SUB, R_Y,    R_MEAS, R_ANG};
         5'd15: s = '{OP_ADD, R_S,    R_AA,   R_MN};
         5'd16: s = '{OP_DIV, R_KA,   R_AA,   R_S};
         5'd17: s = '{OP_DIV, R_KB,   R_BA,   R_S};
         5'd18: s = '{OP_MUL, R_M,    R_KA,   R_Y};
         5'd19: s = '{OP_ADD, R_ANG,  R_ANG,  R_M};
         5'd20: s = '{OP_MUL, R_M,    R_KB,   R_Y};
         5'd21: s = '{OP_ADD, R_BIAS, R_BIAS, R_M};
         5'd22: s = '{OP_ADD, R_T,    R_AA,   R_ZERO};   // keep pre-update aa
         5'd23: s = '{OP_ADD, R_Y,    R_AB,   R_ZERO};   // keep pre-update ab
         5'd24: s = '{OP_MUL, R_M,    R_KA,   R_T};
         5'd25: s = '{OP_SUB, R_AA,   R_T,    R_M};
         5'd26: s = '{OP_MUL, R_M,    R_KA,   R_Y};
         5'd27: s = '{OP_SUB, R_AB,   R_Y,    R_M};
         5'd28: s = '{OP_MUL, R_M,    R_KB,   R_T};
         5'd29: s = '{OP_SUB, R_BA,   R_BA,   R_M};
         5'd30: s = '{OP_MUL, R_M,    R_KB,   R_Y};
         5'd31: s = '{OP_SUB, R_BB,   R_BB,   R_M};
         default: s = '{OP_ADD, R_T, R_ZERO, R_ZERO};
      endcase
      return s;
   endfunction

endpackage

FILE: hdl/gakf_serial_unit.sv
// Bit-serial Q16.32 multiply and divide, one bit per cycle, rounded and saturated.
module gakf_serial_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  gakf_pkg::cmd_type                 cmd,
   input  logic signed [gakf_pkg::W-1:0]     op_a,
   input  logic signed [gakf_pkg::W-1:0]     op_b,   // divisor must be positive
   output gakf_pkg::res_type                 res
);
   localparam int W = gakf_pkg::W;
   localparam int CNT_W = $clog2(W);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(W - 1);

   logic busy_ff, fin_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic is_div_ff, neg_ff, ovf_ff;
   logic [W-1:0] u_ff;       // multiplicand / divisor
   logic [W-1:0] bsh_ff;     // multiplier bits / remaining dividend bits
   logic [W:0]   hi_ff;      // product high half / remainder
   logic [W-1:0] lo_ff;      // product low half / quotient
   logic signed [W-1:0] res_ff;

   logic [W-1:0] mag_a, mag_b;
   logic [W:0]   mul_sum, div_try, div_diff;
   logic         div_take;
   logic         rnd;
   logic [W:0]   q2;
   logic         big;
   logic [W-2:0] m47;
   logic signed [W-1:0] final_val;

   always_comb begin
      mag_a = op_a[W-1] ? W'(-op_a) : op_a;
      mag_b = op_b[W-1] ? W'(-op_b) : op_b;
      mul_sum = hi_ff + (bsh_ff[0] ? {1'b0, u_ff} : '0);
      div_try = {hi_ff[W-1:0], bsh_ff[W-1]};
      div_diff = div_try - {1'b0, u_ff};
      div_take = div_try >= {1'b0, u_ff};
      rnd = {hi_ff[W-1:0], 1'b0} >= {1'b0, u_ff};
      q2 = {1'b0, lo_ff} + (W+1)'(rnd);
      if (is_div_ff) begin
         big = ovf_ff | (|q2[W:W-1]);
         m47 = q2[W-2:0];
      end else begin
         big = |hi_ff[W-1:W-17];
         m47 = {hi_ff[W-18:0], lo_ff[W-1:32]};
      end
      if (big) final_val = neg_ff ? gakf_pkg::VMIN : gakf_pkg::VMAX;
      else if (neg_ff) final_val = -$signed({1'b0, m47});
      else final_val = $signed({1'b0, m47});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff == LAST_CNT) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cnt_ff    <= '0;
         is_div_ff <= cmd.is_div;
         if (cmd.is_div) begin
            neg_ff <= op_a[W-1];
            u_ff   <= op_b;
            ovf_ff <= {16'b0, mag_a[W-1:16]} >= op_b;
            hi_ff  <= {17'b0, mag_a[W-1:16]};
            bsh_ff <= {mag_a[15:0], 32'b0};
            lo_ff  <= '0;
         end else begin
            neg_ff <= op_a[W-1] ^ op_b[W-1];
            u_ff   <= mag_a;
            ovf_ff <= 1'b0;
            hi_ff  <= (W+1)'(64'h8000_0000);   // rounding half lsb
            bsh_ff <= mag_b;
            lo_ff  <= '0;
         end
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (is_div_ff) begin
            hi_ff  <= div_take ? div_diff : div_try;
            lo_ff  <= {lo_ff[W-2:0], div_take};
            bsh_ff <= {bsh_ff[W-2:0], 1'b0};
         end else begin
            hi_ff  <= {1'b0, mul_sum[W:1]};
            lo_ff  <= {mul_sum[0], lo_ff[W-1:1]};
            bsh_ff <= {1'b0, bsh_ff[W-1:1]};
         end
      end
      if (fin_ff) res_ff <= final_val;
   end

   assign res.done  = done_ff;
   assign res.value = res_ff;

endmodule

FILE: hdl/gyro_angle_kalman_filter_top.sv
// Two-state angle / gyro-bias Kalman filter in signed Q16.32 (48-bit), all results
// saturated. Each req transaction carries time_step, measured_angle and gyro_rate; it
// produces one rsp transaction with the updated angle and bias estimates. The block
// handles one item at a time: a 32-step sequencer runs the predict and correct
// equations through one shared bit-serial multiply/divide unit. 13 of those steps
// (11 multiplies, 2 divides) use the serial unit (issue, serial bit steps, round,
// write back), a divide only while the innovation variance is positive; the 19
// others are adds and subtracts. The user must write noise registers over the csr
// channel only while idle; the block does not enforce this. Index 3 is ignored.
module gyro_angle_kalman_filter_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] time_step, [79:32] measured_angle, [127:80] gyro_rate
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [47:0] angle_estimate, [95:48] bias_estimate
   output logic [95:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [46:0]  csr_data
);
   localparam int W = gakf_pkg::W;
   localparam logic [gakf_pkg::PC_W-1:0] LAST_PC = gakf_pkg::PC_W'(gakf_pkg::NUM_STEPS - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [gakf_pkg::PC_W-1:0] pc_ff, pc_in;

   // filter state and scratch
   logic signed [W-1:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [W-1:0] aa_ff, aa_in, ab_ff, ab_in, ba_ff, ba_in, bb_ff, bb_in;
   logic signed [W-1:0] t_ff, t_in, y_ff, y_in, s_ff, s_in;
   logic signed [W-1:0] ka_ff, ka_in, kb_ff, kb_in, m_ff, m_in;
   logic signed [W-1:0] meas_ff, rate_ff;
   logic [31:0] dt_ff;
   logic [W-2:0] qa_ff, qb_ff, mn_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff;

   gakf_pkg::step_type  step;
   gakf_pkg::cmd_type   cmd;
   gakf_pkg::res_type   res;
   logic signed [W-1:0] va, vb, wb_val;
   logic signed [W:0]   sum;
   logic signed [W-1:0] sum_sat;
   logic                wb_en;
   logic                s_pos;
   logic                req_take;

   function automatic logic signed [W-1:0] pick(
      input gakf_pkg::reg_type sel,
      input logic signed [W-1:0] ang, bias, aa, ab, ba, bb, t, y, s, ka, kb, m,
      input logic signed [W-1:0] meas, rate,
      input logic [31:0] dt,
      input logic [W-2:0] qa, qb, mn);
      logic signed [W-1:0] v;
      v = '0;
      unique case (sel)
         gakf_pkg::R_ANG:  v = ang;
         gakf_pkg::R_BIAS: v = bias;
         gakf_pkg::R_AA:   v = aa;
         gakf_pkg::R_AB:   v = ab;
         gakf_pkg::R_BA:   v = ba;
         gakf_pkg::R_BB:   v = bb;
         gakf_pkg::R_T:    v = t;
         gakf_pkg::R_Y:    v = y;
         gakf_pkg::R_S:    v = s;
         gakf_pkg::R_KA:   v = ka;
         gakf_pkg::R_KB:   v = kb;
         gakf_pkg::R_M:    v = m;
         gakf_pkg::R_MEAS: v = meas;
         gakf_pkg::R_RATE: v = rate;
         gakf_pkg::R_DT:   v = $signed({16'b0, dt});
         gakf_pkg::R_QA:   v = $signed({1'b0, qa});
         gakf_pkg::R_QB:   v = $signed({1'b0, qb});
         gakf_pkg::R_MN:   v = $signed({1'b0, mn});
         gakf_pkg::R_ZERO: v = '0;
         default:          v = '0;
      endcase
      return v;
   endfunction

   assign step = gakf_pkg::program_step(pc_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      va = pick(step.sa, ang_ff, bias_ff, aa_ff, ab_ff, ba_ff, bb_ff, t_ff, y_ff, s_ff,
                ka_ff, kb_ff, m_ff, meas_ff, rate_ff, dt_ff, qa_ff, qb_ff, mn_ff);
      vb = pick(step.sb, ang_ff, bias_ff, aa_ff, ab_ff, ba_ff, bb_ff, t_ff, y_ff, s_ff,
                ka_ff, kb_ff, m_ff, meas_ff, rate_ff, dt_ff, qa_ff, qb_ff, mn_ff);
      if (step.op == gakf_pkg::OP_SUB) sum = {va[W-1], va} - {vb[W-1], vb};
      else sum = {va[W-1], va} + {vb[W-1], vb};
      // saturate when the 49-bit sum does not fit in 48 bits
      if (sum[W] != sum[W-1]) sum_sat = sum[W] ? gakf_pkg::VMIN : gakf_pkg::VMAX;
      else sum_sat = sum[W-1:0];
      s_pos = !s_ff[W-1] && (s_ff != '0);
   end

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      cmd.start = 1'b0;
      cmd.is_div = (step.op == gakf_pkg::OP_DIV);
      wb_en = 1'b0;
      wb_val = sum_sat;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
               pc_in = '0;
            end
         end
         ST_EXEC: begin
            priority if (step.op == gakf_pkg::OP_ADD || step.op == gakf_pkg::OP_SUB) begin
               wb_en = 1'b1;
            end else if (step.op == gakf_pkg::OP_DIV && !s_pos) begin
               // innovation variance not positive: gain is zero
               wb_en = 1'b1;
               wb_val = '0;
            end else begin
               cmd.start = 1'b1;
               state_in = ST_WAIT;
            end
            if (wb_en) begin
               if (pc_ff == LAST_PC) state_in = ST_OUT;
               else pc_in = pc_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            if (res.done) begin
               wb_en = 1'b1;
               wb_val = res.value;
               if (pc_ff == LAST_PC) state_in = ST_OUT;
               else begin
                  pc_in = pc_ff + 1'b1;
                  state_in = ST_EXEC;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // write back
   always_comb begin
      ang_in = ang_ff; bias_in = bias_ff; aa_in = aa_ff; ab_in = ab_ff;
      ba_in = ba_ff; bb_in = bb_ff; t_in = t_ff; y_in = y_ff; s_in = s_ff;
      ka_in = ka_ff; kb_in = kb_ff; m_in = m_ff;
      if (wb_en) begin
         unique case (step.dst)
            gakf_pkg::R_ANG:  ang_in = wb_val;
            gakf_pkg::R_BIAS: bias_in = wb_val;
            gakf_pkg::R_AA:   aa_in = wb_val;
            gakf_pkg::R_AB:   ab_in = wb_val;
            gakf_pkg::R_BA:   ba_in = wb_val;
            gakf_pkg::R_BB:   bb_in = wb_val;
            gakf_pkg::R_T:    t_in = wb_val;
            gakf_pkg::R_Y:    y_in = wb_val;
            gakf_pkg::R_S:    s_in = wb_val;
            gakf_pkg::R_KA:   ka_in = wb_val;
            gakf_pkg::R_KB:   kb_in = wb_val;
            gakf_pkg::R_M:    m_in = wb_val;
            default:          m_in = m_ff;   // inputs and constants are read-only
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ang_ff <= '0;
         bias_ff <= '0;
         aa_ff <= gakf_pkg::COV_RESET;
         ab_ff <= '0;
         ba_ff <= '0;
         bb_ff <= gakf_pkg::COV_RESET;
         qa_ff <= gakf_pkg::ANGLE_NOISE_RESET;
         qb_ff <= gakf_pkg::BIAS_NOISE_RESET;
         mn_ff <= gakf_pkg::MEAS_NOISE_RESET;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         ang_ff <= ang_in;
         bias_ff <= bias_in;
         aa_ff <= aa_in;
         ab_ff <= ab_in;
         ba_ff <= ba_in;
         bb_ff <= bb_in;
         if (csr_valid && csr_ready) begin
            unique case (gakf_pkg::csr_index_type'(csr_index))
               gakf_pkg::CSR_ANGLE_NOISE: qa_ff <= csr_data;
               gakf_pkg::CSR_BIAS_NOISE:  qb_ff <= csr_data;
               gakf_pkg::CSR_MEAS_NOISE:  mn_ff <= csr_data;
               gakf_pkg::CSR_UNUSED:      qa_ff <= qa_ff;
               default:                   qa_ff <= qa_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      t_ff <= t_in;
      y_ff <= y_in;
      s_ff <= s_in;
      ka_ff <= ka_in;
      kb_ff <= kb_in;
      m_ff <= m_in;
      if (req_take) begin
         dt_ff <= req_tdata[31:0];
         meas_ff <= req_tdata[79:32];
         rate_ff <= req_tdata[127:80];
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {bias_ff, ang_ff};
      end
   end

   gakf_serial_unit u_serial (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .op_a  (va),
      .op_b  (step.op == gakf_pkg::OP_DIV ? s_ff : vb),
      .res   (res)
   );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SAT_LO = -64'sh0000_8000_0000_0000;
   localparam longint CYCLE_LIMIT = 8_000_000;
   localparam int RANDOM_ITEMS = 930;

   // Predicts the filter's estimates and holds them until the block reports them.
   class kalman_scoreboard;
      longint angle, bias, p_aa, p_ab, p_ba, p_bb;
      longint q_angle, q_bias, r_meas;
      logic [47:0] exp_angle[$];
      logic [47:0] exp_bias[$];
      int mismatches;

      function new();
         angle = 0; bias = 0;
         p_aa = 64'sd10 <<< 32; p_ab = 0; p_ba = 0; p_bb = 64'sd10 <<< 32;
         q_angle = 429; q_bias = 42950; r_meas = 64'sd2 <<< 32;
         mismatches = 0;
      endfunction

      function longint clamp(longint v);
         if (v > SAT_HI) return SAT_HI;
         if (v < SAT_LO) return SAT_LO;
         return v;
      endfunction

      function longint unsigned magnitude(longint v);
         return v < 0 ? -v : v;
      endfunction

      function longint sign_clamp(longint unsigned m, bit neg);
         if (neg) return (m >= 64'h8000_0000_0000) ? SAT_LO : -longint'(m);
         return (m > 64'h7FFF_FFFF_FFFF) ? SAT_HI : longint'(m);
      endfunction

      // Q16.32 product, rounded half away from zero
      function longint fx_mul(longint a, longint b);
         longint unsigned ua, ub, prod;
         ua = magnitude(a);
         ub = magnitude(b);
         prod = ((ua >> 32) * (ub >> 32)) << 32;
         prod += (ua >> 32) * (ub & 32'hFFFF_FFFF) + (ua & 32'hFFFF_FFFF) * (ub >> 32);
         prod += ((ua & 32'hFFFF_FFFF) * (ub & 32'hFFFF_FFFF) + 64'h8000_0000) >> 32;
         return sign_clamp(prod, (a < 0) != (b < 0));
      endfunction

      // Q16.32 quotient, divisor positive
      function longint fx_div(longint a, longint b);
         longint unsigned ua, ub, q, r;
         ua = magnitude(a);
         ub = b;
         q = ua / ub;
         r = ua % ub;
         if (q >= 64'h1_0000) return sign_clamp(64'h8000_0000_0000, a < 0);
         for (int i = 0; i < 32; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ub) begin
               r -= ub;
               q |= 1;
            end
         end
         if (2 * r >= ub) q += 1;
         return sign_clamp(q, a < 0);
      endfunction

      function void write_reg(gakf_pkg::csr_index_type idx, logic [46:0] val);
         case (idx)
            gakf_pkg::CSR_ANGLE_NOISE: q_angle = longint'(val);
            gakf_pkg::CSR_BIAS_NOISE:  q_bias = longint'(val);
            gakf_pkg::CSR_MEAS_NOISE:  r_meas = longint'(val);
            default: ;
         endcase
      endfunction

      function void note_input(logic [31:0] dt_bits, logic [47:0] meas_bits,
                               logic [47:0] rate_bits);
         longint dt, meas, rate, t, y, s, ka, kb, aa0, ab0;
         dt = longint'(dt_bits);
         meas = longint'(signed'(meas_bits));
         rate = longint'(signed'(rate_bits));
         // predict
         t = clamp(rate - bias);
         angle = clamp(angle + fx_mul(dt, t));
         t = fx_mul(p_bb, dt);
         t = clamp(t - p_ab);
         t = clamp(t - p_ba);
         t = clamp(t + q_angle);
         p_aa = clamp(p_aa + fx_mul(dt, t));
         t = fx_mul(p_bb, dt);
         p_ab = clamp(p_ab - t);
         p_ba = clamp(p_ba - t);
         p_bb = clamp(p_bb + fx_mul(q_bias, dt));
         // correct; a non-positive innovation variance zeroes both gains
         y = clamp(meas - angle);
         s = clamp(p_aa + r_meas);
         ka = (s > 0) ? fx_div(p_aa, s) : 0;
         kb = (s > 0) ? fx_div(p_ba, s) : 0;
         angle = clamp(angle + fx_mul(ka, y));
         bias = clamp(bias + fx_mul(kb, y));
         aa0 = p_aa;
         ab0 = p_ab;
         p_aa = clamp(aa0 - fx_mul(ka, aa0));
         p_ab = clamp(ab0 - fx_mul(ka, ab0));
         p_ba = clamp(p_ba - fx_mul(kb, aa0));
         p_bb = clamp(p_bb - fx_mul(kb, ab0));
         exp_angle.push_back(angle[47:0]);
         exp_bias.push_back(bias[47:0]);
      endfunction

      function void check_result(logic [47:0] got_angle, logic [47:0] got_bias);
         logic [47:0] ea, eb;
         if (exp_angle.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp transaction: angle %h bias %h", got_angle, got_bias);
            return;
         end
         ea = exp_angle.pop_front();
         eb = exp_bias.pop_front();
         if (got_angle !== ea || got_bias !== eb) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp mismatch: angle exp %h got %h, bias exp %h got %h",
                        ea, got_angle, eb, got_bias);
         end
      endfunction

      function int pending();
         return exp_angle.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = gakf_pkg::CSR_ANGLE_NOISE;
   logic [46:0]  csr_data = '0;

   kalman_scoreboard sb = new();
   longint cycles = 0;
   int burst_left = 0;
   logic [15:0] stall_pattern = 16'hFFFF;

   gyro_angle_kalman_filter_top dut (.*);

   always #5 clock = ~clock;

   // Watchdog: a run that hangs or loses results ends here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: every rsp transaction is checked against the oldest prediction.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[47:0], rsp_tdata[95:48]);

   // Receiver back-pressure: a rotating stall pattern, reloaded now and then;
   // an all-ones pattern gives stretches with no stalls.
   always @(negedge clock) begin
      if ($urandom_range(0, 299) == 0)
         case ($urandom_range(0, 3))
            0: stall_pattern <= 16'hFFFF;
            1: stall_pattern <= 16'($urandom);
            2: stall_pattern <= 16'h0001;
            default: stall_pattern <= 16'($urandom) | 16'h8421;
         endcase
      else
         stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      rsp_tready <= stall_pattern[15];
   end

   // One csr transaction; only called while the filter is idle.
   task automatic write_csr(gakf_pkg::csr_index_type idx, logic [46:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One req transaction, then a random gap at the end of each burst.
   task automatic send_item(logic [31:0] dt, logic [47:0] meas, logic [47:0] rate);
      req_tvalid = 1'b1;
      req_tdata = {rate, meas, dt};
      do @(posedge clock); while (!req_tready);
      sb.note_input(dt, meas, rate);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 6);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 40)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   // Mostly plausible IMU samples; a share of full-range values covers every bit.
   task automatic send_random();
      logic [31:0] dt;
      logic [47:0] meas, rate;
      if ($urandom_range(0, 9) == 0) begin
         dt = $urandom;
         meas = rand48();
         rate = rand48();
      end else begin
         dt = $urandom_range(0, 32'h0400_0000);
         meas = 48'(longint'($urandom_range(0, 32'h00FF_FFFF)) * 256
                    - 64'sh0000_8000_0000);
         rate = 48'(longint'($urandom_range(0, 32'h00FF_FFFF)) * 4096
                    - 64'sh0008_0000_0000);
      end
      send_item(dt, meas, rate);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes at reset configuration.
      send_item(32'd0, 48'd0, 48'd0);
      send_item(32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
      send_item(32'hFFFF_FFFF, 48'h8000_0000_0000, 48'h8000_0000_0000);
      send_item(32'h0100_0000, 48'h0000_0001_0000, 48'hFFFF_FFFF_0000);
      send_item(32'h0000_0001, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001);
      send_item(32'h8000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
      send_item(32'hFFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
      drain();

      // Zero measurement noise: gains collapse once the covariance goes non-positive.
      write_csr(gakf_pkg::CSR_MEAS_NOISE, 47'd0);
      write_csr(gakf_pkg::CSR_UNUSED, 47'h7FFF_FFFF_FFFF);      // ignored index
      for (int i = 0; i < 6; i++) send_item($urandom, rand48(), rand48());
      drain();

      // Largest noise settings.
      write_csr(gakf_pkg::CSR_ANGLE_NOISE, 47'h7FFF_FFFF_FFFF);
      write_csr(gakf_pkg::CSR_BIAS_NOISE, 47'h7FFF_FFFF_FFFF);
      write_csr(gakf_pkg::CSR_MEAS_NOISE, 47'h7FFF_FFFF_FFFF);
      for (int i = 0; i < 6; i++) send_item($urandom, rand48(), rand48());
      drain();

      // Random phases, each under a fresh noise setting.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_csr(gakf_pkg::CSR_ANGLE_NOISE, 47'd429);
               write_csr(gakf_pkg::CSR_BIAS_NOISE, 47'd42950);
               write_csr(gakf_pkg::CSR_MEAS_NOISE, 47'd8589934592);
            end
            1: begin
               write_csr(gakf_pkg::CSR_ANGLE_NOISE, 47'd0);
               write_csr(gakf_pkg::CSR_BIAS_NOISE, 47'd0);
               write_csr(gakf_pkg::CSR_MEAS_NOISE, 47'd1);
            end
            default: begin
               write_csr(gakf_pkg::CSR_ANGLE_NOISE,
                         47'($urandom_range(0, 32'h00FF_FFFF)));
               write_csr(gakf_pkg::CSR_BIAS_NOISE, 47'($urandom));
               write_csr(gakf_pkg::CSR_MEAS_NOISE, 47'(rand48()) | 47'd1);
            end
         endcase
         for (int i = 0; i < RANDOM_ITEMS / 5; i++) send_random();
         drain();
      end

      repeat (1000) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/gakf_pkg.sv
hdl/gakf_serial_unit.sv
hdl/gyro_angle_kalman_filter_top.sv
sim/testbench.sv
